FILE: design/kbpc_pkg.sv
// Shared types and constants for the knob and button player control block.
// No dependencies; imported by kbpc_led_bar and knob_button_player_control.
`timescale 1ns / 1ps
`default_nettype none

package kbpc_pkg;

	localparam int VOL_W      = 4;
	localparam int TENTHS_W   = 16;
	localparam int CFG_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int LED_PAT_W  = 24;
	localparam int LED_BITS   = 3;
	localparam int LED_COUNT_DEF = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SLEEP_HOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAKE_WINDOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_VOLUME  = 2'd2;

	localparam logic [CFG_W-1:0] SLEEP_HOLD_RST  = 8'd50;
	localparam logic [CFG_W-1:0] WAKE_WINDOW_RST = 8'd5;
	localparam logic [VOL_W-1:0] MAX_VOLUME_RST  = 4'd8;
	localparam logic [VOL_W-1:0] VOLUME_RST      = 4'd4;

	localparam logic [1:0] SONG_NONE = 2'd0;
	localparam logic [1:0] SONG_NEXT = 2'd1;
	localparam logic [1:0] SONG_PREV = 2'd2;

	localparam logic [LED_BITS-1:0] LED_PLAY  = 3'd4;
	localparam logic [LED_BITS-1:0] LED_PAUSE = 3'd2;
	localparam logic [LED_BITS-1:0] LED_SLEEP = 3'd1;

	typedef struct packed {
		logic             asleep;
		logic             playing;
		logic [VOL_W-1:0] volume;
	} kbpc_mode_t;

endpackage

`default_nettype wire

FILE: design/knob_button_player_control.sv
// Top level of the knob and button player control: poll decode, mode state,
// configuration registers and result register. Depends on kbpc_pkg, kbpc_led_bar.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | switch_pressed, encoder_delta, tick
//   out     | output    | out_valid/out_ready | playing, asleep, volume_level,
//           |           |                     | song_step, led_pattern, display_refresh
//   cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One poll per cycle unless the result is held: the mode state and the result
// register load at the same edge, so a result appears in the cycle after its transaction is accepted.
// in_ready is high while the result register is empty or being taken.
// cfg_ready is always high. Reset loads the default registers and start volume.
`timescale 1ns / 1ps
`default_nettype none

module knob_button_player_control #(
	parameter int LED_COUNT = kbpc_pkg::LED_COUNT_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire                                   switch_pressed,
	input  wire signed [7:0]                      encoder_delta,
	input  wire                                   tick,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output logic                                  playing,
	output logic                                  asleep,
	output logic [kbpc_pkg::VOL_W-1:0]            volume_level,
	output logic [1:0]                            song_step,
	output logic [kbpc_pkg::LED_PAT_W-1:0]        led_pattern,
	output logic                                  display_refresh,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [kbpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire  [kbpc_pkg::CFG_W-1:0]            cfg_data
);
	import kbpc_pkg::*;

	logic [CFG_W-1:0]    sleep_hold_q, wake_window_q;
	logic [VOL_W-1:0]    max_volume_q;

	logic                last_sw_q, scrolled_q, sleep_q, fresh_sleep_q, play_q;
	logic [TENTHS_W-1:0] mark_q, now_q;
	logic [VOL_W-1:0]    volume_q;

	logic                last_sw_d, scrolled_d, sleep_d, fresh_sleep_d, play_d;
	logic [TENTHS_W-1:0] mark_d, now_d;
	logic [VOL_W-1:0]    volume_d;
	logic [1:0]          song_d;
	logic                refresh_d;
	logic [TENTHS_W-1:0] wake_elapsed, hold_elapsed;

	kbpc_mode_t          mode_d;
	logic [LED_PAT_W-1:0] pattern_d;
	logic                accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid || out_ready;
	assign accept    = in_valid && in_ready;

	always_comb begin
		now_d         = tick ? now_q + 1'b1 : now_q;
		last_sw_d     = last_sw_q;
		scrolled_d    = scrolled_q;
		sleep_d       = sleep_q;
		fresh_sleep_d = fresh_sleep_q;
		play_d        = play_q;
		mark_d        = mark_q;
		volume_d      = volume_q;
		song_d        = SONG_NONE;
		refresh_d     = 1'b0;
		wake_elapsed  = now_d - mark_q;

		if (switch_pressed != last_sw_q) begin
			if (switch_pressed) begin
				scrolled_d = 1'b0;
				if (!sleep_q) mark_d = now_d;
			end else if (!scrolled_q) begin
				if (sleep_q) begin
					if (wake_elapsed < {8'd0, wake_window_q}) begin
						sleep_d = 1'b0;
					end else if (!fresh_sleep_q) begin
						mark_d = now_d;
					end
					fresh_sleep_d = 1'b0;
				end else begin
					play_d = !play_q;
				end
			end
			last_sw_d = switch_pressed;
			refresh_d = 1'b1;
		end

		hold_elapsed = now_d - mark_d;
		if (last_sw_d && !sleep_d && !scrolled_d && hold_elapsed >= {8'd0, sleep_hold_q}) begin
			sleep_d       = 1'b1;
			fresh_sleep_d = 1'b1;
			refresh_d     = 1'b1;
		end

		if (encoder_delta != 8'sd0) begin
			if (!sleep_d) begin
				if (!encoder_delta[7]) begin
					if (switch_pressed) song_d = SONG_NEXT;
					else if (volume_q >= max_volume_q) volume_d = max_volume_q;
					else volume_d = volume_q + 1'b1;
				end else begin
					if (switch_pressed) song_d = SONG_PREV;
					else if (volume_q != '0) volume_d = volume_q - 1'b1;
				end
			end
			refresh_d  = 1'b1;
			scrolled_d = 1'b1;
		end

		mode_d.asleep  = sleep_d;
		mode_d.playing = play_d;
		mode_d.volume  = volume_d;
	end

	kbpc_led_bar #(
		.LED_COUNT(LED_COUNT)
	) u_led_bar (
		.mode    (mode_d),
		.pattern (pattern_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sleep_hold_q  <= SLEEP_HOLD_RST;
			wake_window_q <= WAKE_WINDOW_RST;
			max_volume_q  <= MAX_VOLUME_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SLEEP_HOLD:  sleep_hold_q  <= cfg_data;
				REG_WAKE_WINDOW: wake_window_q <= cfg_data;
				REG_MAX_VOLUME:  max_volume_q  <= cfg_data[VOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sw_q     <= 1'b0;
			scrolled_q    <= 1'b0;
			sleep_q       <= 1'b0;
			fresh_sleep_q <= 1'b0;
			play_q        <= 1'b0;
			mark_q        <= '0;
			now_q         <= '0;
			volume_q      <= VOLUME_RST;
			out_valid     <= 1'b0;
		end else begin
			if (accept) begin
				last_sw_q     <= last_sw_d;
				scrolled_q    <= scrolled_d;
				sleep_q       <= sleep_d;
				fresh_sleep_q <= fresh_sleep_d;
				play_q        <= play_d;
				mark_q        <= mark_d;
				now_q         <= now_d;
				volume_q      <= volume_d;
				out_valid     <= 1'b1;
			end else if (out_ready) begin
				out_valid     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			playing         <= play_d;
			asleep          <= sleep_d;
			volume_level    <= volume_d;
			song_step       <= song_d;
			led_pattern     <= pattern_d;
			display_refresh <= refresh_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/kbpc_led_bar.sv
// LED bar pattern from the next player mode: volume bar or sleep marker.
// Depends on kbpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kbpc_led_bar #(
	parameter int LED_COUNT = kbpc_pkg::LED_COUNT_DEF
) (
	input  wire kbpc_pkg::kbpc_mode_t               mode,
	output logic [kbpc_pkg::LED_PAT_W-1:0]         pattern
);
	import kbpc_pkg::*;

	always_comb begin
		pattern = '0;
		if (mode.asleep) begin
			pattern[LED_BITS*(LED_COUNT-1) +: LED_BITS] = LED_SLEEP;
		end else begin
			for (int i = 0; i < LED_COUNT; i++) begin
				if (5'(i + 1) <= {1'b0, mode.volume}) begin
					pattern[LED_BITS*i +: LED_BITS] = mode.playing ? LED_PLAY : LED_PAUSE;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: tb/knob_button_player_control_tb.sv
`timescale 1ns / 1ps
// Testbench for knob_button_player_control: directed polls, then gesture-shaped random
// polls under random idling on both channels, each result checked by a scoreboard class.
// Depends on kbpc_pkg and the knob_button_player_control RTL.

module knob_button_player_control_tb;
	import kbpc_pkg::*;

	localparam int LEDS    = LED_COUNT_DEF;
	localparam int MAX_GAP = 17;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic                 playing;
		logic                 asleep;
		logic [VOL_W-1:0]     volume;
		logic [1:0]           song;
		logic [LED_PAT_W-1:0] leds;
		logic                 refresh;
	} poll_result_t;

	class player_scoreboard;
		logic [CFG_W-1:0]    hold_r;
		logic [CFG_W-1:0]    window_r;
		logic [VOL_W-1:0]    maxv_r;
		logic                last_sw;
		logic                scrolled;
		logic                sleeping;
		logic                fresh_sleep;
		logic                play;
		logic [TENTHS_W-1:0] mark;
		logic [TENTHS_W-1:0] now_t;
		logic [VOL_W-1:0]    vol;
		poll_result_t        expected_polls[$];
		int                  errors;
		int                  checked;
		int                  sleeps;
		int                  wakes;
		int                  songs;

		function new();
			hold_r      = SLEEP_HOLD_RST;
			window_r    = WAKE_WINDOW_RST;
			maxv_r      = MAX_VOLUME_RST;
			last_sw     = 1'b0;
			scrolled    = 1'b0;
			sleeping    = 1'b0;
			fresh_sleep = 1'b0;
			play        = 1'b0;
			mark        = '0;
			now_t       = '0;
			vol         = VOLUME_RST;
			errors      = 0;
			checked     = 0;
			sleeps      = 0;
			wakes       = 0;
			songs       = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_SLEEP_HOLD: hold_r = data;
				REG_WAKE_WINDOW: window_r = data;
				REG_MAX_VOLUME: maxv_r = data[VOL_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [LED_PAT_W-1:0] led_bar();
			logic [LED_PAT_W-1:0] pat;
			pat = '0;
			if (sleeping) begin
				pat[LED_BITS*(LEDS-1) +: LED_BITS] = LED_SLEEP;
			end else begin
				for (int i = 0; i < LEDS; i++) begin
					if (i + 1 <= vol)
						pat[LED_BITS*i +: LED_BITS] = play ? LED_PLAY : LED_PAUSE;
				end
			end
			return pat;
		endfunction

		function void note_poll(logic sw, logic [7:0] enc, logic tk);
			poll_result_t r;
			logic         refresh;
			logic [1:0]   song;
			refresh = 1'b0;
			song    = SONG_NONE;
			if (tk)
				now_t = now_t + 1'b1;
			if (sw != last_sw) begin
				if (sw) begin
					scrolled = 1'b0;
					if (!sleeping)
						mark = now_t;
				end else if (!scrolled) begin
					if (sleeping) begin
						if (TENTHS_W'(now_t - mark) < TENTHS_W'(window_r)) begin
							sleeping = 1'b0;
							wakes++;
						end else if (!fresh_sleep) begin
							mark = now_t;
						end
						fresh_sleep = 1'b0;
					end else begin
						play = !play;
					end
				end
				last_sw = sw;
				refresh = 1'b1;
			end
			if (last_sw && !sleeping && !scrolled &&
			    TENTHS_W'(now_t - mark) >= TENTHS_W'(hold_r)) begin
				sleeping    = 1'b1;
				fresh_sleep = 1'b1;
				refresh     = 1'b1;
				sleeps++;
			end
			if (enc != 8'h00) begin
				if (!sleeping) begin
					if (!enc[7]) begin
						if (sw)
							song = SONG_NEXT;
						else if (vol >= maxv_r)
							vol = maxv_r;
						else
							vol = vol + 1'b1;
					end else begin
						if (sw)
							song = SONG_PREV;
						else if (vol != '0)
							vol = vol - 1'b1;
					end
				end
				refresh  = 1'b1;
				scrolled = 1'b1;
			end
			if (song != SONG_NONE)
				songs++;
			r.playing = play;
			r.asleep  = sleeping;
			r.volume  = vol;
			r.song    = song;
			r.leds    = led_bar();
			r.refresh = refresh;
			expected_polls.push_back(r);
		endfunction

		function void check_poll_result(poll_result_t got);
			poll_result_t want;
			if (expected_polls.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with no poll pending: %p", $realtime, got);
				return;
			end
			want = expected_polls.pop_front();
			checked++;
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("%0t: result %0d mismatch", $realtime, checked);
					$display("  expected play=%0b sleep=%0b vol=%0d song=%0d leds=%06h refresh=%0b",
						want.playing, want.asleep, want.volume, want.song, want.leds,
						want.refresh);
					$display("  actual   play=%0b sleep=%0b vol=%0d song=%0d leds=%06h refresh=%0b",
						got.playing, got.asleep, got.volume, got.song, got.leds,
						got.refresh);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   switch_pressed;
	logic [7:0]             encoder_delta;
	logic                   tick;
	logic                   out_valid;
	logic                   out_ready;
	logic                   playing;
	logic                   asleep;
	logic [VOL_W-1:0]       volume_level;
	logic [1:0]             song_step;
	logic [LED_PAT_W-1:0]   led_pattern;
	logic                   display_refresh;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	player_scoreboard sb = new();
	bit no_idle;
	int polls_sent;
	int cfg_writes;

	knob_button_player_control DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.switch_pressed (switch_pressed),
		.encoder_delta  (encoder_delta),
		.tick           (tick),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.playing        (playing),
		.asleep         (asleep),
		.volume_level   (volume_level),
		.song_step      (song_step),
		.led_pattern    (led_pattern),
		.display_refresh(display_refresh),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_poll_result({playing, asleep, volume_level, song_step,
					led_pattern, display_refresh});
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && in_ready)
				sb.note_poll(switch_pressed, encoder_delta, tick);
		end
	end

	function automatic int idle_draw();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic rand_tick();
		return $urandom_range(0, 2) == 0;
	endfunction

	function automatic logic [7:0] turn_delta();
		int mag;
		mag = $urandom_range(1, 3);
		case ($urandom_range(0, 7))
			0: return 8'h7F;
			1: return 8'h80;
			2, 3, 4: return 8'(256 - mag);
			default: return 8'(mag);
		endcase
	endfunction

	task automatic send_poll(input logic sw, input logic [7:0] enc, input logic tk);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		switch_pressed <= sw;
		encoder_delta  <= enc;
		tick           <= tk;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		polls_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_polls.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_config(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] window,
	                            input logic [CFG_W-1:0] vol_data, input bit junk);
		logic [CFG_IDX_W-1:0] idx[4];
		logic [CFG_W-1:0]     val[4];
		int                   n;
		idx[0] = REG_SLEEP_HOLD;
		val[0] = hold;
		idx[1] = REG_WAKE_WINDOW;
		val[1] = window;
		idx[2] = REG_MAX_VOLUME;
		val[2] = vol_data;
		idx[3] = REG_UNUSED;
		val[3] = 8'($urandom_range(0, 255));
		n = junk ? 4 : 3;
		for (int k = 0; k < n; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cfg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_poll(1'b0, 8'h00, 1'b0);
		send_poll(1'b1, 8'h00, 1'b1);
		send_poll(1'b0, 8'h00, 1'b1);
		send_poll(1'b0, 8'h7F, 1'b0);
		send_poll(1'b0, 8'h80, 1'b0);
		send_poll(1'b1, 8'h01, 1'b0);
		send_poll(1'b1, 8'hFF, 1'b1);
		send_poll(1'b0, 8'h00, 1'b0);
		drain();
		write_config(8'd1, 8'd2, 8'h08, 1'b0);
		// hold into sleep, turn while asleep, then double tap to wake
		send_poll(1'b1, 8'h00, 1'b1);
		send_poll(1'b1, 8'h00, 1'b1);
		send_poll(1'b1, 8'h05, 1'b0);
		send_poll(1'b0, 8'h00, 1'b1);
		send_poll(1'b1, 8'h00, 1'b1);
		send_poll(1'b0, 8'h00, 1'b0);
		send_poll(1'b1, 8'h00, 1'b0);
		send_poll(1'b0, 8'h00, 1'b1);
		send_poll(1'b0, 8'h07, 1'b0);
		drain();
		write_config(8'd1, 8'd2, 8'hF0, 1'b1);
		send_poll(1'b0, 8'h01, 1'b0);
		send_poll(1'b0, 8'hFF, 1'b0);
		drain();
		write_config(8'd255, 8'd255, 8'h0F, 1'b0);
		send_poll(1'b0, 8'h7F, 1'b1);
		send_poll(1'b0, 8'h7F, 1'b0);
	endtask

	task automatic play_gesture();
		int   n;
		logic held;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				n = $urandom_range(1, 3);
				repeat (n) send_poll(1'b1, 8'h00, rand_tick());
				send_poll(1'b0, 8'h00, rand_tick());
			end
			3: begin
				n = sb.hold_r + $urandom_range(1, 3);
				repeat (n) send_poll(1'b1, 8'h00, $urandom_range(0, 7) != 0);
				send_poll(1'b0, 8'h00, 1'b0);
			end
			4, 5: begin
				repeat (2) begin
					send_poll(1'b1, 8'h00, rand_tick());
					send_poll(1'b0, 8'h00, rand_tick());
				end
			end
			6, 7: begin
				held = $urandom_range(0, 2) == 0;
				n = $urandom_range(1, 6);
				repeat (n) send_poll(held, turn_delta(), rand_tick());
				if (held)
					send_poll(1'b0, 8'h00, rand_tick());
			end
			8: begin
				repeat ($urandom_range(1, 4))
					send_poll(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					          1'($urandom_range(0, 1)));
			end
			default: begin
				repeat ($urandom_range(1, 5)) send_poll(1'b0, 8'h00, 1'b1);
			end
		endcase
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = idle_draw();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		int target;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		switch_pressed = 1'b0;
		encoder_delta  = 8'h00;
		tick           = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_SLEEP_HOLD;
		cfg_data       = 8'h00;
		no_idle        = 1'b0;
		polls_sent     = 0;
		cfg_writes     = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int ph = 0; ph < 10; ph++) begin
			drain();
			case (ph)
				0: write_config(8'd1, 8'd1, 8'h00, 1'b1);
				1: write_config(8'd255, 8'd255, 8'h0F, 1'b0);
				2: write_config(8'd2, 8'd3, {4'($urandom_range(0, 15)), 4'd1}, 1'b0);
				default: begin
					write_config(($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
					                                         : 8'($urandom_range(1, 8)),
					             ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
					                                         : 8'($urandom_range(1, 12)),
					             8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end
			endcase
			no_idle = (ph % 4 == 3);
			target = polls_sent + 200;
			while (polls_sent < target) play_gesture();
		end
		drain();
		write_config(8'd6, 8'd4, 8'h0A, 1'b0);
		no_idle = 1'b0;
		target = polls_sent + 200;
		while (polls_sent < target) play_gesture();
		drain();
		$display("%0d polls sent, %0d results checked, %0d config writes", polls_sent,
			sb.checked, cfg_writes);
		$display("%0d sleep entries, %0d wakeups, %0d song requests, %0d errors", sb.sleeps,
			sb.wakes, sb.songs, sb.errors);
		if (sb.errors == 0 && sb.expected_polls.size() == 0)
			$display("knob_button_player_control_tb: done, clean");
		else
			$display("knob_button_player_control_tb: done, errors");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("knob_button_player_control_tb: done, errors");
		$finish;
	end

endmodule

FILE: knob_button_player_control.f
design/kbpc_pkg.sv
design/kbpc_led_bar.sv
design/knob_button_player_control.sv
tb/knob_button_player_control_tb.sv
